[sv/met_pkg.sv]
package met_pkg;

   localparam int FRAC_BITS   = 58;
   localparam int MAX_RES     = 1024;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // escape radius squared, 4.0 in the fixed-point format
   localparam logic signed [63:0] FOUR = 64'(64'd4 << FRAC_BITS);

   localparam logic signed [63:0] LEFT_EDGE_RST   = 64'(64'd0 - (64'd3 << FRAC_BITS));
   localparam logic signed [63:0] BOTTOM_EDGE_RST = 64'(64'd0 - (64'd1 << FRAC_BITS));
   localparam logic [62:0] STEP_X_RST =
      63'((64'd1 << FRAC_BITS) * 64'd4 / 64'(MAX_RES));
   localparam logic [62:0] STEP_Y_RST =
      63'((64'd1 << FRAC_BITS) * 64'd2 / 64'(MAX_RES));
   localparam logic [15:0] MAX_ITER_RST = 16'd50;

   typedef enum logic [2:0] {
      CSR_LEFT_EDGE   = 3'd0,
      CSR_BOTTOM_EDGE = 3'd1,
      CSR_STEP_X      = 3'd2,
      CSR_STEP_Y      = 3'd3,
      CSR_MAX_ITER    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_ADD,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_MXX,
      B_MYY,
      B_MXY,
      B_SUB,
      B_ADD,
      B_TEST
   } back_state_type;

   typedef struct packed {
      logic signed [63:0] cx;
      logic signed [63:0] cy;
      logic               ovf;
   } pt_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic               ovf;
      logic signed [63:0] value;
   } mul_res_type;

   typedef struct packed {
      logic               ovf;
      logic signed [63:0] value;
   } sum_type;

   function automatic sum_type add_chk(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
      logic signed [64:0] s;
      sum_type            r;
      s       = {a[63], a} + {b[63], b};
      r.ovf   = s[64] ^ s[63];
      r.value = s[63:0];
      return r;
   endfunction

endpackage

[sv/met_front.sv]
module met_front import met_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [9:0]         pixel_col,
   input  logic [9:0]         pixel_row,
   input  logic signed [63:0] left_edge,
   input  logic signed [63:0] bottom_edge,
   input  logic [62:0]        step_x,
   input  logic [62:0]        step_y,
   input  logic               q_full,
   output logic               busy,
   output logic               q_push,
   output pt_type             q_data
);

   localparam logic [12:0] MAX_RES_W = 13'(MAX_RES);
   localparam logic [9:0]  RES_TOP   = 10'(MAX_RES - 1);

   front_state_type    state_ff, state_in;
   logic               axis_ff, axis_in;
   logic [9:0]         col_ff, col_in;
   logic [10:0]        row_ff, row_in;
   logic [42:0]        pp_lo_ff, pp_lo_in;
   logic [41:0]        pp_hi_ff, pp_hi_in;
   logic signed [63:0] cx_ff, cx_in;
   logic signed [63:0] cy_ff, cy_in;
   logic               ovf_ff, ovf_in;

   logic [10:0]        idx;
   logic [62:0]        stp;
   logic signed [63:0] edge_sel;
   logic [73:0]        prod;
   sum_type            csum;

   function automatic logic [9:0] res_sat(input logic [9:0] v);
      if ({3'd0, v} >= MAX_RES_W) begin
         return RES_TOP;
      end
      return v;
   endfunction

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      pp_lo_in = pp_lo_ff;
      pp_hi_in = pp_hi_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      ovf_in   = ovf_ff;
      q_push   = 1'b0;

      idx      = axis_ff ? row_ff : {1'b0, col_ff};
      stp      = axis_ff ? step_y : step_x;
      edge_sel = axis_ff ? bottom_edge : left_edge;
      prod     = {31'd0, pp_lo_ff} + {pp_hi_ff, 32'd0};
      csum     = add_chk(edge_sel, {1'b0, prod[62:0]});

      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               col_in   = res_sat(pixel_col);
               row_in   = {1'b0, res_sat(pixel_row)} + 11'd1;
               axis_in  = 1'b0;
               ovf_in   = 1'b0;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            // split the step into halves to keep each product narrow
            pp_lo_in = {32'd0, idx} * {11'd0, stp[31:0]};
            pp_hi_in = {31'd0, idx} * {11'd0, stp[62:32]};
            state_in = F_ADD;
         end
         F_ADD: begin
            ovf_in = ovf_ff | (|prod[73:63]) | csum.ovf;
            if (axis_ff) begin
               cy_in    = csum.value;
               state_in = F_PUSH;
            end else begin
               cx_in    = csum.value;
               axis_in  = 1'b1;
               state_in = F_MUL;
            end
         end
         F_PUSH: begin
            // hold until the queue has room
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff  <= axis_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      ovf_ff   <= ovf_in;
   end

   assign busy   = (state_ff != F_IDLE);
   assign q_data = '{cx: cx_ff, cy: cy_ff, ovf: ovf_ff};

endmodule

[sv/met_queue.sv]
module met_queue import met_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  pt_type push_data,
   input  logic   pop,
   output pt_type pop_data,
   output logic   full,
   output logic   empty
);

   pt_type            ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

   assign full    = (cnt_ff == CNT_FULL);
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = ent_ff[rd_ptr_ff];

endmodule

[sv/met_mul.sv]
module met_mul import met_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_res_type res
);

   logic               run_ff, run_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [63:0]        ma_ff, ma_in;
   logic [63:0]        mb_ff, mb_in;
   logic               neg_ff, neg_in;
   logic [63:0]        pp_ff, pp_in;
   logic [1:0]         sh_ff, sh_in;
   logic               pp_vld_ff, pp_vld_in;
   logic [127:0]       acc_ff, acc_in;
   logic               done_ff, done_in;
   logic               ovf_ff, ovf_in;
   logic signed [63:0] val_ff, val_in;

   logic [31:0]        a_half;
   logic [31:0]        b_half;
   logic [127:0]       q;
   logic               fin;

   always_comb begin
      run_in    = run_ff;
      cnt_in    = cnt_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      neg_in    = neg_ff;
      pp_in     = pp_ff;
      sh_in     = sh_ff;
      pp_vld_in = 1'b0;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      ovf_in    = ovf_ff;
      val_in    = val_ff;

      a_half = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      b_half = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      q      = acc_ff >> FRAC_BITS;
      fin    = run_ff && (cnt_ff == 3'd4) && !pp_vld_ff;

      if (req.start) begin
         ma_in  = req.a[63] ? 64'd0 - req.a : req.a;
         mb_in  = req.b[63] ? 64'd0 - req.b : req.b;
         neg_in = req.a[63] ^ req.b[63];
         cnt_in = 3'd0;
         acc_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (cnt_ff != 3'd4) begin
            pp_in     = {32'd0, a_half} * {32'd0, b_half};
            sh_in     = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            pp_vld_in = 1'b1;
            cnt_in    = cnt_ff + 3'd1;
         end
         if (pp_vld_ff) begin
            acc_in = acc_ff + ({64'd0, pp_ff} << {sh_ff, 5'd0});
         end
         if (fin) begin
            // truncate the magnitude, then apply the sign
            run_in  = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               ovf_in = (|q[127:64]) || (q[63] && (|q[62:0]));
               val_in = 64'd0 - q[63:0];
            end else begin
               ovf_in = (|q[127:64]) || q[63];
               val_in = q[63:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         cnt_ff    <= 3'd0;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         run_ff    <= run_in;
         cnt_ff    <= cnt_in;
         pp_vld_ff <= pp_vld_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      ovf_ff <= ovf_in;
      val_ff <= val_in;
   end

   assign res = '{done: done_ff, ovf: ovf_ff, value: val_ff};

endmodule

[sv/met_iter.sv]
module met_iter import met_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  pt_type      q_data,
   output logic        q_pop,
   input  logic [15:0] max_iter,
   output mul_req_type mul_req,
   input  mul_res_type mul_res,
   output logic        rsp_valid,
   output logic        rsp_escaped
);

   back_state_type     state_ff, state_in;
   logic               wait_ff, wait_in;
   logic               chk_ff, chk_in;
   logic [15:0]        iter_ff, iter_in;
   logic signed [63:0] cx_ff, cx_in;
   logic signed [63:0] cy_ff, cy_in;
   logic signed [63:0] zx_ff, zx_in;
   logic signed [63:0] zy_ff, zy_in;
   logic signed [63:0] xx_ff, xx_in;
   logic signed [63:0] yy_ff, yy_in;
   logic signed [63:0] xy_ff, xy_in;
   logic               vld_ff, vld_in;
   logic               esc_ff, esc_in;

   sum_type            s_d;
   sum_type            s_t;
   sum_type            s_zx;
   sum_type            s_zy;
   sum_type            s_mag;

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      chk_in   = chk_ff;
      iter_in  = iter_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      zx_in    = zx_ff;
      zy_in    = zy_ff;
      xx_in    = xx_ff;
      yy_in    = yy_ff;
      xy_in    = xy_ff;
      vld_in   = 1'b0;
      esc_in   = esc_ff;
      q_pop    = 1'b0;

      mul_req.start = 1'b0;
      mul_req.a     = zx_ff;
      mul_req.b     = (state_ff == B_MXX) ? zx_ff : zy_ff;

      s_d   = add_chk(xx_ff, 64'sd0 - yy_ff);
      s_t   = add_chk(xy_ff, xy_ff);
      s_zx  = add_chk(xx_ff, cx_ff);
      s_zy  = add_chk(xy_ff, cy_ff);
      s_mag = add_chk(xx_ff, yy_ff);

      if (state_ff == B_MYY) begin
         mul_req.a = zy_ff;
      end

      unique case (state_ff) inside
         B_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               cx_in   = q_data.cx;
               cy_in   = q_data.cy;
               zx_in   = q_data.cx;
               zy_in   = q_data.cy;
               iter_in = 16'd0;
               chk_in  = 1'b0;
               if (q_data.ovf) begin
                  vld_in = 1'b1;
                  esc_in = 1'b1;
               end else if (max_iter == 16'd0) begin
                  vld_in = 1'b1;
                  esc_in = 1'b0;
               end else begin
                  state_in = B_MXX;
               end
            end
         end
         B_MXX, B_MYY, B_MXY: begin
            if (!wait_ff) begin
               mul_req.start = 1'b1;
               wait_in       = 1'b1;
            end else if (mul_res.done) begin
               wait_in = 1'b0;
               if (mul_res.ovf) begin
                  vld_in   = 1'b1;
                  esc_in   = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  unique case (state_ff)
                     B_MXX: begin
                        xx_in    = mul_res.value;
                        state_in = B_MYY;
                     end
                     B_MYY: begin
                        yy_in    = mul_res.value;
                        state_in = chk_ff ? B_TEST : B_MXY;
                     end
                     default: begin
                        xy_in    = mul_res.value;
                        state_in = B_SUB;
                     end
                  endcase
               end
            end
         end
         B_SUB: begin
            if (s_d.ovf || s_t.ovf) begin
               vld_in   = 1'b1;
               esc_in   = 1'b1;
               state_in = B_IDLE;
            end else begin
               xx_in    = s_d.value;
               xy_in    = s_t.value;
               state_in = B_ADD;
            end
         end
         B_ADD: begin
            if (s_zx.ovf || s_zy.ovf) begin
               vld_in   = 1'b1;
               esc_in   = 1'b1;
               state_in = B_IDLE;
            end else begin
               zx_in    = s_zx.value;
               zy_in    = s_zy.value;
               chk_in   = 1'b1;
               state_in = B_MXX;
            end
         end
         B_TEST: begin
            // the squares just taken are the next round's xx and yy
            if (s_mag.ovf || (s_mag.value > FOUR)) begin
               vld_in   = 1'b1;
               esc_in   = 1'b1;
               state_in = B_IDLE;
            end else if (({1'b0, iter_ff} + 17'd1) == {1'b0, max_iter}) begin
               vld_in   = 1'b1;
               esc_in   = 1'b0;
               state_in = B_IDLE;
            end else begin
               iter_in  = iter_ff + 16'd1;
               state_in = B_MXY;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         wait_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff  <= chk_in;
      iter_ff <= iter_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      zx_ff   <= zx_in;
      zy_ff   <= zy_in;
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      xy_ff   <= xy_in;
      esc_ff  <= esc_in;
   end

   assign rsp_valid   = vld_ff;
   assign rsp_escaped = esc_ff;

endmodule

[sv/mandelbrot_escape_test_top.sv]
// Escape-time test of one pixel of the Mandelbrot set in signed fixed point.
// Request: raise start with req_pixel_col / req_pixel_row; the beat is taken
// at a rising edge where start is high and busy is low. Busy stays high
// while the front end forms the point c = edge + index*step and queues it.
// The point then waits in a two-entry queue for the iteration engine, so the
// front end can take the next pixel while the engine is still working.
// Response: rsp_valid is high for exactly one cycle with rsp_escaped; the
// receiver cannot stall, and responses come back in request order.
// Each iteration takes three 64x64 products through one shared 32x32
// multiplier, each built from its four partial products, plus the add and
// test steps; the first two squares come before the first iteration.
// The engine works on one pixel at a time; the front end takes a new pixel
// only after it has queued the last one.
// A point that has escaped or overflowed finishes early; one that stays
// bounded takes max_iterations iterations.
// Configuration: csr_wr_en writes csr_wdata to register csr_index at once;
// write only while no pixel is outstanding. Unknown indexes are ignored.
// Reset: synchronous, active high; clears the queue and the engine and
// loads the default view (-3.0, -1.0, 4/1024, 2/1024, 50 iterations).
module mandelbrot_escape_test_top import met_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_pixel_col,
   input  logic [9:0]  req_pixel_row,
   output logic        rsp_valid,
   output logic        rsp_escaped,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic signed [63:0] left_edge_ff;
   logic signed [63:0] bottom_edge_ff;
   logic [62:0]        step_x_ff;
   logic [62:0]        step_y_ff;
   logic [15:0]        max_iter_ff;

   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   pt_type             q_wdata;
   pt_type             q_rdata;
   mul_req_type        mul_req;
   mul_res_type        mul_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_edge_ff   <= LEFT_EDGE_RST;
         bottom_edge_ff <= BOTTOM_EDGE_RST;
         step_x_ff      <= STEP_X_RST;
         step_y_ff      <= STEP_Y_RST;
         max_iter_ff    <= MAX_ITER_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEFT_EDGE:   left_edge_ff   <= csr_wdata;
            CSR_BOTTOM_EDGE: bottom_edge_ff <= csr_wdata;
            CSR_STEP_X:      step_x_ff      <= csr_wdata[62:0];
            CSR_STEP_Y:      step_y_ff      <= csr_wdata[62:0];
            CSR_MAX_ITER:    max_iter_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   met_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .pixel_col   (req_pixel_col),
      .pixel_row   (req_pixel_row),
      .left_edge   (left_edge_ff),
      .bottom_edge (bottom_edge_ff),
      .step_x      (step_x_ff),
      .step_y      (step_y_ff),
      .q_full      (q_full),
      .busy        (busy),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   met_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   met_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .res   (mul_res)
   );

   met_iter u_iter (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .max_iter    (max_iter_ff),
      .mul_req     (mul_req),
      .mul_res     (mul_res),
      .rsp_valid   (rsp_valid),
      .rsp_escaped (rsp_escaped)
   );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top import met_pkg::*; ();

   localparam int Q_FRAC      = 58;
   localparam int PIX_SPAN    = 1024;
   localparam int SETTLE      = 30;
   localparam int STALL_LIMIT = 20000;
   localparam int VIEWS       = 8;
   localparam int PIX_PER_VIEW = 71;
   localparam int IDLE_PCT [3] = '{25, 81, 0};

   localparam logic signed [63:0] RADIUS_SQ = 64'sd4 <<< Q_FRAC;
   localparam logic [63:0] S64_MAX  = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = '1;
   localparam logic [63:0] ONE_Q    = 64'd1 << Q_FRAC;
   localparam logic [2:0]  CSR_UNMAPPED [3] = '{3'd5, 3'd6, 3'd7};

   typedef enum logic [1:0] {OUT_MODEL, OUT_BOUNDED, OUT_ESCAPED} outcome_type;
   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   reg_idx;
      logic [63:0]  value;
      logic [9:0]   px_col;
      logic [9:0]   px_row;
      outcome_type  want;
   } stim_row_type;

   typedef struct packed {
      logic [9:0] col;
      logic [9:0] row;
      logic       escaped;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [9:0]  req_pixel_col;
   logic [9:0]  req_pixel_row;
   logic        rsp_valid;
   logic        rsp_escaped;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   // local copy of the view registers
   logic signed [63:0] view_left;
   logic signed [63:0] view_bottom;
   logic [62:0]        view_step_x;
   logic [62:0]        view_step_y;
   logic [15:0]        view_iters;

   pixel_result_type escape_due[$];
   outcome_type      fixed_outcome[$];
   pixel_result_type due_beat;
   outcome_type      acc_want;
   logic             acc_escape;
   int               idle_pct = 0;
   int               errors = 0;
   int               checked = 0;
   int               escaped_seen = 0;
   int               views_loaded = 0;
   int               stall_cycles = 0;

   mandelbrot_escape_test_top DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel_col (req_pixel_col),
      .req_pixel_row (req_pixel_row),
      .rsp_valid     (rsp_valid),
      .rsp_escaped   (rsp_escaped),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // product of two Q6.58 values, truncated toward zero; 0 on overflow
   function automatic bit q_mul(input logic signed [63:0] a, input logic signed [63:0] b,
                                output logic signed [63:0] r);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      logic [63:0]  q;
      ma   = a[63] ? 64'd0 - a : a;
      mb   = b[63] ? 64'd0 - b : b;
      prod = ({64'd0, ma} * {64'd0, mb}) >> Q_FRAC;
      if (prod[127:64] != 0) return 1'b0;
      q = prod[63:0];
      if (a[63] ^ b[63]) begin
         if (q > S64_MIN) return 1'b0;
         r = 64'd0 - q;
      end else begin
         if (q[63]) return 1'b0;
         r = q;
      end
      return 1'b1;
   endfunction

   function automatic bit q_add(input logic signed [63:0] a, input logic signed [63:0] b,
                                output logic signed [63:0] r);
      r = a + b;
      return !((a[63] == b[63]) && (r[63] != a[63]));
   endfunction

   function automatic logic predict_escape(input logic [9:0] col, input logic [9:0] row);
      logic [127:0]       off;
      logic signed [63:0] cx, cy, zx, zy, xx, yy, xy, d, t2, sa, sb, s;
      int unsigned        it;
      off = 128'(col) * 128'(view_step_x);
      if (off > 128'(S64_MAX)) return 1'b1;
      if (!q_add(view_left, off[63:0], cx)) return 1'b1;
      off = (128'(row) + 128'd1) * 128'(view_step_y);
      if (off > 128'(S64_MAX)) return 1'b1;
      if (!q_add(view_bottom, off[63:0], cy)) return 1'b1;
      zx = cx;
      zy = cy;
      for (it = 0; it < view_iters; it++) begin
         if (!q_mul(zx, zx, xx) || !q_mul(zy, zy, yy) || !q_mul(zx, zy, xy)) return 1'b1;
         if (!q_add(xx, -yy, d) || !q_add(d, cx, zx)) return 1'b1;
         if (!q_add(xy, xy, t2) || !q_add(t2, cy, zy)) return 1'b1;
         if (!q_mul(zx, zx, sa) || !q_mul(zy, zy, sb) || !q_add(sa, sb, s)) return 1'b1;
         if (s > RADIUS_SQ) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic stim_row_type dir_pixel(input logic [9:0] col, input logic [9:0] row,
                                              input outcome_type want);
      stim_row_type e;
      e = '{ROW_PIXEL, CSR_LEFT_EDGE, 64'd0, col, row, want};
      return e;
   endfunction

   function automatic stim_row_type dir_write(input logic [2:0] idx, input logic [63:0] value);
      stim_row_type e;
      e = '{ROW_CSR, idx, value, 10'd0, 10'd0, OUT_MODEL};
      return e;
   endfunction

   // check responses, then log the beat taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (escape_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, escaped=%0b", $time, rsp_escaped);
            end else begin
               due_beat = escape_due.pop_front();
               checked++;
               if (rsp_escaped === 1'b1) escaped_seen++;
               if (rsp_escaped !== due_beat.escaped) begin
                  errors++;
                  $display("%0t: pixel (%0d,%0d) escaped: expected %0b, got %0b", $time,
                           due_beat.col, due_beat.row, due_beat.escaped, rsp_escaped);
               end
            end
         end
         if (start && !busy) begin
            acc_want = (fixed_outcome.size() != 0) ? fixed_outcome.pop_front() : OUT_MODEL;
            case (acc_want)
               OUT_BOUNDED: acc_escape = 1'b0;
               OUT_ESCAPED: acc_escape = 1'b1;
               default:     acc_escape = predict_escape(req_pixel_col, req_pixel_row);
            endcase
            escape_due.push_back('{req_pixel_col, req_pixel_row, acc_escape});
         end
         if ((start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
                     stall_cycles, escape_due.size());
            $display("tb_top failed");
            $finish;
         end
      end
   end

   // all driving tasks enter and leave on a falling edge
   task automatic send_pixel(input logic [9:0] col, input logic [9:0] row,
                             input outcome_type want);
      while ($urandom_range(0, 99) < idle_pct) begin
         start         <= 1'b0;
         req_pixel_col <= 10'($urandom);
         req_pixel_row <= 10'($urandom);
         @(negedge clock);
      end
      fixed_outcome.push_back(want);
      start         <= 1'b1;
      req_pixel_col <= col;
      req_pixel_row <= row;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (escape_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_LEFT_EDGE:   view_left   = value;
         CSR_BOTTOM_EDGE: view_bottom = value;
         CSR_STEP_X:      view_step_x = value[62:0];
         CSR_STEP_Y:      view_step_y = value[62:0];
         CSR_MAX_ITER:    view_iters  = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_random_view();
      logic [63:0] l, b, sx, sy, junk;
      logic [15:0] n;
      int          kind;
      kind = $urandom_range(0, 9);
      l    = rand64();
      b    = rand64();
      sx   = rand64();
      sy   = rand64();
      if (kind <= 5) begin
         // whole set in view, roughly -2.5..1.5 by -1.5..2.5
         l  = 64'd0 - (64'd5 << (Q_FRAC - 1)) + (rand64() >> 5);
         b  = 64'd0 - (64'd3 << (Q_FRAC - 1)) + (rand64() >> 5);
         sx = rand64() >> 14;
         sy = rand64() >> 14;
      end else if (kind <= 7) begin
         // zoom near the boundary
         l  = 64'd0 - (64'd3 << (Q_FRAC - 1)) + (rand64() >> 6);
         b  = 64'd0 - (64'd1 << (Q_FRAC - 1)) + (rand64() >> 6);
         sx = rand64() >> 20;
         sy = rand64() >> 20;
      end else if (kind == 8) begin
         l  = $signed(l) >>> 3;
         b  = $signed(b) >>> 3;
         sx = rand64() >> 9;
         sy = rand64() >> 9;
      end
      sx[63] = 1'($urandom_range(0, 1));
      sy[63] = 1'($urandom_range(0, 1));
      n    = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(17, 64))
                                         : 16'($urandom_range(1, 16));
      junk = rand64();
      write_csr(CSR_LEFT_EDGE, l);
      write_csr(CSR_BOTTOM_EDGE, b);
      write_csr(CSR_STEP_X, sx);
      write_csr(CSR_STEP_Y, sy);
      write_csr(CSR_MAX_ITER, {junk[63:16], n});
      views_loaded++;
   endtask

   initial begin
      stim_row_type directed[$];
      logic [9:0]   col, row;
      reset         = 1'b1;
      start         = 1'b0;
      req_pixel_col = '0;
      req_pixel_row = '0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_LEFT_EDGE;
      csr_wdata     = '0;
      view_left     = 64'd0 - (64'd3 << Q_FRAC);
      view_bottom   = 64'd0 - ONE_Q;
      view_step_x   = 63'((64'd4 << Q_FRAC) / PIX_SPAN);
      view_step_y   = 63'((64'd2 << Q_FRAC) / PIX_SPAN);
      view_iters    = 16'd50;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      directed = '{
         // default view after reset
         dir_pixel(10'd0, 10'd0, OUT_ESCAPED),
         dir_pixel(10'd1023, 10'd1023, OUT_ESCAPED),
         dir_pixel(10'd512, 10'd511, OUT_BOUNDED),     // c = -1, period two
         dir_pixel(10'd768, 10'd511, OUT_BOUNDED),     // c = 0
         dir_pixel(10'd256, 10'd511, OUT_BOUNDED),     // c = -2, |z|^2 stays exactly 4
         dir_pixel(10'd832, 10'd511, OUT_MODEL),       // c = 0.25, cusp
         dir_pixel(10'd700, 10'd300, OUT_MODEL),
         dir_pixel(10'd1023, 10'd0, OUT_MODEL),
         dir_pixel(10'd0, 10'd1023, OUT_MODEL),
         dir_pixel(10'd341, 10'd682, OUT_MODEL),
         // no iterations at all
         dir_write(CSR_MAX_ITER, 64'd0),
         dir_pixel(10'd0, 10'd0, OUT_BOUNDED),
         dir_pixel(10'd1023, 10'd1023, OUT_BOUNDED),
         dir_write(CSR_MAX_ITER, 64'd1),
         dir_pixel(10'd0, 10'd0, OUT_ESCAPED),
         dir_pixel(10'd768, 10'd511, OUT_BOUNDED),
         // overflow of the point itself or of its first square, longest limit
         dir_write(CSR_MAX_ITER, ALL_ONES),
         dir_write(CSR_LEFT_EDGE, S64_MAX),
         dir_write(CSR_STEP_X, ALL_ONES),
         dir_pixel(10'd0, 10'd511, OUT_ESCAPED),
         dir_pixel(10'd1, 10'd511, OUT_ESCAPED),
         dir_pixel(10'd1023, 10'd0, OUT_ESCAPED),
         dir_write(CSR_LEFT_EDGE, S64_MIN),
         dir_write(CSR_STEP_X, 64'd0),
         dir_pixel(10'd5, 10'd511, OUT_ESCAPED),
         // imaginary extremes with real part held at zero
         dir_write(CSR_MAX_ITER, 64'd3),
         dir_write(CSR_LEFT_EDGE, 64'd0),
         dir_write(CSR_BOTTOM_EDGE, S64_MIN),
         dir_write(CSR_STEP_Y, ALL_ONES),
         dir_pixel(10'd9, 10'd0, OUT_MODEL),
         dir_pixel(10'd9, 10'd1, OUT_ESCAPED),
         dir_write(CSR_STEP_Y, 64'd0),
         dir_pixel(10'd9, 10'd1023, OUT_ESCAPED),
         dir_write(CSR_BOTTOM_EDGE, S64_MAX),
         dir_write(CSR_STEP_Y, 64'd1),
         dir_pixel(10'd9, 10'd0, OUT_ESCAPED),
         // writes to unmapped indexes must leave the view alone
         dir_write(CSR_BOTTOM_EDGE, 64'd0 - ONE_Q),
         dir_write(CSR_STEP_Y, (64'd2 << Q_FRAC) / PIX_SPAN),
         dir_write(CSR_UNMAPPED[0], S64_MAX),
         dir_write(CSR_UNMAPPED[1], S64_MAX),
         dir_write(CSR_UNMAPPED[2], S64_MAX),
         dir_pixel(10'd1, 10'd511, OUT_BOUNDED),
         dir_pixel(10'd300, 10'd600, OUT_MODEL)
      };

      idle_pct = IDLE_PCT[0];
      foreach (directed[k]) begin
         if (directed[k].kind == ROW_CSR) begin
            drain();
            write_csr(directed[k].reg_idx, directed[k].value);
         end else begin
            send_pixel(directed[k].px_col, directed[k].px_row, directed[k].want);
         end
      end

      foreach (IDLE_PCT[p]) begin
         idle_pct = IDLE_PCT[p];
         repeat (VIEWS) begin
            // hold off until the engine is empty before changing the view
            drain();
            load_random_view();
            repeat (PIX_PER_VIEW) begin
               col = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                                  : 10'($urandom_range(0, 1023));
               row = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                                  : 10'($urandom_range(0, 1023));
               send_pixel(col, row, OUT_MODEL);
            end
         end
      end
      drain();

      $display("Checked %0d pixels (%0d escaped) over the default view and %0d random views,",
               checked, escaped_seen, views_loaded);
      $display("  including overflow, zero and maximum iteration limits; %0d mismatches", errors);
      if (errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule
